// ===== rtl/core/ffa_pkg.sv =====
`default_nettype none
package ffa_pkg;

	localparam int unsigned ARENA_BYTES_DEF = 4096;
	localparam int unsigned HDR_BYTES       = 2;
	localparam int unsigned SUM_W           = 17;
	localparam int unsigned PAYLOAD_W       = 12;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_SIZE = 3'd1,
		ST_NO_FIT   = 3'd2,
		ST_BAD_ADDR = 3'd3,
		ST_NOT_USED = 3'd4
	} status_t;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	// payload length of a signed header
	function automatic logic [15:0] hdr_len(input logic [15:0] h);
		return h[15] ? (~h + 16'd1) : h;
	endfunction

	function automatic logic hdr_free(input logic [15:0] h);
		return ~h[15];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ffa_hdr_ram.sv =====
`default_nettype none
module ffa_hdr_ram #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW    = 12
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [15:0]   wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [15:0]   rdata
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/core/first_fit_heap_allocator.sv =====
// first-fit heap allocator over a byte arena of ARENA_BYTES bytes
//
// input channel s_*: one transaction is one request
//   s_tuser  : func (0 allocate, 1 free)
//   s_tdata  : request_size [15:0], free_address [31:16]
// output channel m_*: one result transaction per request
//   m_tdata  : status [2:0], payload_address [14:3], zero [15]
//
// the block takes one request at a time; s_tready is high only while idle
// allocate walks the header chain block by block, merging a free block with a
// free successor, then splits off the remainder where it fits and marks the
// block used; free walks the chain to the target and frees it, then sweeps
// the whole chain again to coalesce free neighbours; a request rejected on its
// size or address bounds skips the walk; the result is registered into
// m_tvalid once the output register is free; header reads share one read port
// a result waits in the output register until taken; while the receiver
// stalls one more request may finish and then holds the sequencer, so no
// further request enters
// reset clears the sequencer, the output register and the arena-initialised
// flag; the arena is set up by the first allocate, no clearing pass is run
`default_nettype none
module first_fit_heap_allocator
	import ffa_pkg::*;
#(
	parameter int unsigned ARENA_BYTES = ARENA_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // request_size, free_address
	input  wire logic        s_tuser,  // func
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [15:0] m_tdata   // status, payload_address, zero pad
);

	localparam int unsigned AW = $clog2(ARENA_BYTES);

	typedef enum logic [3:0] {
		S_IDLE, S_A_RD, S_A_LAT, S_A_EV, S_A_NRD, S_A_NX, S_A_FIT, S_A_TOG,
		S_F_RD, S_F_LAT, S_F_EV, S_C_RD, S_C_LAT, S_C_EV, S_C_NRD, S_C_NX
	} state_t;

	state_t               state_q;
	logic                 init_q;
	logic                 split_q;
	logic                 done_q;
	logic [AW-1:0]        cur_q;
	logic [AW-1:0]        nxt_q;
	logic [AW-1:0]        target_q;
	logic [15:0]          req_q;
	logic [15:0]          hcur_q;
	status_t              st_q;
	logic [PAYLOAD_W-1:0] pay_q;

	logic [15:0]    rdata;
	logic           mem_we;
	logic [AW-1:0]  mem_wa;
	logic [15:0]    mem_wd;
	logic [AW-1:0]  mem_ra;

	logic [15:0]       len_cur;
	logic [15:0]       len_rd;
	logic [15:0]       merged;
	logic [SUM_W-1:0]  nxt_sum;
	logic              has_next;
	logic [SUM_W-1:0]  split_sum;
	logic              split_ok;
	logic              accept;
	logic [15:0]       in_req;
	logic [15:0]       in_addr;
	logic              bad_size;
	logic              bad_addr;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE) && !done_q;
	assign in_req   = s_tdata[15:0];
	assign in_addr  = s_tdata[31:16];
	assign bad_size = (in_req == 16'd0) || ({1'b0, in_req} > SUM_W'(ARENA_BYTES - HDR_BYTES));
	assign bad_addr = (in_addr < 16'(HDR_BYTES)) || ({1'b0, in_addr} >= SUM_W'(ARENA_BYTES));

	assign len_cur   = hdr_len(hcur_q);
	assign len_rd    = hdr_len(rdata);
	assign merged    = len_cur + 16'(HDR_BYTES) + len_rd;
	assign nxt_sum   = SUM_W'(cur_q) + SUM_W'(HDR_BYTES) + SUM_W'(len_cur);
	assign has_next  = nxt_sum < SUM_W'(ARENA_BYTES);
	assign split_sum = SUM_W'(cur_q) + SUM_W'(HDR_BYTES) + SUM_W'(req_q);
	assign split_ok  = (SUM_W'(len_cur) >= SUM_W'(req_q) + SUM_W'(HDR_BYTES + 1))
		&& (split_sum < SUM_W'(ARENA_BYTES));

	assign mem_ra = ((state_q == S_A_NRD) || (state_q == S_C_NRD)) ? nxt_q : cur_q;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = cur_q;
		mem_wd = merged;
		unique case (state_q)
			S_IDLE: begin
				mem_we = accept && (s_tuser == FUNC_ALLOC) && !init_q;
				mem_wa = '0;
				mem_wd = 16'(ARENA_BYTES - HDR_BYTES);
			end
			S_A_NX, S_C_NX: begin
				mem_we = hdr_free(rdata);
			end
			S_A_FIT: begin
				mem_we = split_ok;
				mem_wa = split_sum[AW-1:0];
				mem_wd = len_cur - req_q - 16'(HDR_BYTES);
			end
			S_A_TOG: begin
				mem_we = 1'b1;
				mem_wd = split_q ? (~req_q + 16'd1) : (~hcur_q + 16'd1);
			end
			S_F_EV: begin
				mem_we = (cur_q == target_q) && !hdr_free(hcur_q);
				mem_wd = ~hcur_q + 16'd1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	ffa_hdr_ram #(
		.DEPTH(ARENA_BYTES),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_wa),
		.wdata(mem_wd),
		.raddr(mem_ra),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			init_q   <= 1'b0;
			done_q   <= 1'b0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			split_q  <= 1'b0;
			cur_q    <= '0;
			nxt_q    <= '0;
			target_q <= '0;
			req_q    <= '0;
			hcur_q   <= '0;
			st_q     <= ST_OK;
			pay_q    <= '0;
		end else begin
			if (done_q && (!m_tvalid || m_tready)) begin
				m_tvalid <= 1'b1;
				m_tdata  <= {1'b0, pay_q, st_q};
				done_q   <= 1'b0;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q    <= in_req;
						cur_q    <= '0;
						pay_q    <= '0;
						target_q <= AW'(in_addr - 16'(HDR_BYTES));
						if (s_tuser == FUNC_ALLOC) begin
							init_q <= 1'b1;
							if (bad_size) begin
								st_q   <= ST_BAD_SIZE;
								done_q <= 1'b1;
							end else begin
								state_q <= S_A_RD;
							end
						end else if (bad_addr || !init_q) begin
							st_q   <= ST_BAD_ADDR;
							done_q <= 1'b1;
						end else begin
							state_q <= S_F_RD;
						end
					end
				end
				S_A_RD:  state_q <= S_A_LAT;
				S_A_LAT: begin
					hcur_q  <= rdata;
					state_q <= S_A_EV;
				end
				S_A_EV: begin
					nxt_q <= nxt_sum[AW-1:0];
					if (hdr_free(hcur_q) && has_next) begin
						state_q <= S_A_NRD;
					end else if (hdr_free(hcur_q) && (len_cur >= req_q)) begin
						state_q <= S_A_FIT;
					end else if (!has_next) begin
						st_q    <= ST_NO_FIT;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						cur_q   <= nxt_sum[AW-1:0];
						state_q <= S_A_RD;
					end
				end
				S_A_NRD: state_q <= S_A_NX;
				S_A_NX: begin
					if (hdr_free(rdata)) begin
						hcur_q  <= merged;
						state_q <= (merged >= req_q) ? S_A_FIT : S_A_EV;
					end else if (len_cur >= req_q) begin
						state_q <= S_A_FIT;
					end else begin
						cur_q   <= nxt_q;
						hcur_q  <= rdata;
						state_q <= S_A_EV;
					end
				end
				S_A_FIT: begin
					split_q <= split_ok;
					state_q <= S_A_TOG;
				end
				S_A_TOG: begin
					st_q    <= ST_OK;
					pay_q   <= PAYLOAD_W'(SUM_W'(cur_q) + SUM_W'(HDR_BYTES));
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_F_RD:  state_q <= S_F_LAT;
				S_F_LAT: begin
					hcur_q  <= rdata;
					state_q <= S_F_EV;
				end
				S_F_EV: begin
					if (cur_q == target_q) begin
						if (hdr_free(hcur_q)) begin
							st_q    <= ST_NOT_USED;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							cur_q   <= '0;
							state_q <= S_C_RD;
						end
					end else if ((cur_q > target_q) || !has_next) begin
						st_q    <= ST_BAD_ADDR;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						cur_q   <= nxt_sum[AW-1:0];
						state_q <= S_F_RD;
					end
				end
				S_C_RD:  state_q <= S_C_LAT;
				S_C_LAT: begin
					hcur_q  <= rdata;
					state_q <= S_C_EV;
				end
				S_C_EV: begin
					nxt_q <= nxt_sum[AW-1:0];
					if (!has_next) begin
						st_q    <= ST_OK;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (hdr_free(hcur_q)) begin
						state_q <= S_C_NRD;
					end else begin
						cur_q   <= nxt_sum[AW-1:0];
						state_q <= S_C_RD;
					end
				end
				S_C_NRD: state_q <= S_C_NX;
				S_C_NX: begin
					if (hdr_free(rdata)) begin
						hcur_q <= merged;
					end else begin
						cur_q  <= nxt_q;
						hcur_q <= rdata;
					end
					state_q <= S_C_EV;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_init_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(init_q))
		else $error("arena flag dropped");

	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (SUM_W'(mem_wa) < SUM_W'(ARENA_BYTES)))
		else $error("header write outside arena");

	a_pay_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[2:0] != ST_OK)) |-> (m_tdata[14:3] == '0))
		else $error("payload on failed request");

	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("request taken while busy");

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import ffa_pkg::*;

	localparam int unsigned ARENA = ARENA_BYTES_DEF;
	localparam int unsigned LIMIT = 20000000;

	typedef struct packed {
		logic        func;
		logic [15:0] req_size;
		logic [15:0] addr;
	} request_t;

	typedef struct packed {
		status_t     status;
		logic [11:0] payload;
	} grant_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;

	request_t    pending_reqs[$];
	grant_t      expected_grants[$];
	logic [15:0] heap_hdr[ARENA];
	int          live_payloads[$];
	int          errors;
	int          cycles;
	int          burst_left;
	int          gap_left;
	int          hold_left;
	bit          hold_req;
	bit          sender_pause;
	bit          in_acc;
	int          n_alloc_ok;
	int          n_free_ok;
	int          n_rejects;

	first_fit_heap_allocator DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	function automatic int blk_len(int off);
		logic [15:0] v;
		v = heap_hdr[off];
		return v[15] ? int'(17'h10000 - v) : int'(v);
	endfunction

	function automatic bit blk_is_free(int off);
		return heap_hdr[off][15] == 1'b0;
	endfunction

	function automatic bit blk_succ(int off, output int nxt);
		nxt = off + 2 + blk_len(off);
		return nxt < ARENA;
	endfunction

	function automatic void blk_join(int off, int nxt);
		heap_hdr[off] = 16'(blk_len(off) + 2 + blk_len(nxt));
	endfunction

	function automatic void blk_flip(int off);
		heap_hdr[off] = 16'(17'h10000 - heap_hdr[off]);
	endfunction

	function automatic grant_t predict_heap(request_t r);
		grant_t g;
		int cur, nxt, len, req, addr, tgt;
		bit has_nxt, merged;
		g.status = ST_OK;
		g.payload = '0;
		cur = 0;
		req = r.req_size;
		addr = r.addr;
		if (r.func == FUNC_ALLOC) begin
			if (heap_hdr[0] == 0) heap_hdr[0] = 16'(ARENA - 2);
			if (req == 0 || req > ARENA - 2) begin
				g.status = ST_BAD_SIZE;
				return g;
			end
			forever begin
				has_nxt = blk_succ(cur, nxt);
				if (blk_is_free(cur)) begin
					merged = 0;
					if (has_nxt && blk_is_free(nxt)) begin
						blk_join(cur, nxt);
						merged = 1;
					end
					if (blk_len(cur) >= req) break;
					if (merged) continue;
				end
				if (!has_nxt) begin
					g.status = ST_NO_FIT;
					return g;
				end
				cur = nxt;
			end
			len = blk_len(cur);
			if (len >= req + 3 && cur + 2 + req < ARENA) begin
				heap_hdr[cur + 2 + req] = 16'(len - req - 2);
				heap_hdr[cur] = 16'(req);
			end
			blk_flip(cur);
			g.payload = 12'(cur + 2);
			return g;
		end
		if (addr < 2 || addr >= ARENA || heap_hdr[0] == 0) begin
			g.status = ST_BAD_ADDR;
			return g;
		end
		tgt = addr - 2;
		while (cur != tgt) begin
			if (cur > tgt || !blk_succ(cur, nxt)) begin
				g.status = ST_BAD_ADDR;
				return g;
			end
			cur = nxt;
		end
		if (blk_is_free(cur)) begin
			g.status = ST_NOT_USED;
			return g;
		end
		blk_flip(cur);
		cur = 0;
		while (blk_succ(cur, nxt)) begin
			if (blk_is_free(cur) && blk_is_free(nxt)) blk_join(cur, nxt);
			else cur = nxt;
		end
		return g;
	endfunction

	function automatic request_t mk_req(logic func, int sz, int ad);
		request_t r;
		r.func = func;
		r.req_size = 16'(sz);
		r.addr = 16'(ad);
		return r;
	endfunction

	function automatic int pick_size();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 65535);
			1: return $urandom_range(200, 1200);
			default: return $urandom_range(1, 120);
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// driver
	always @(negedge clk or negedge arst_n) begin
		request_t r;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (in_acc) void'(pending_reqs.pop_front());
			if (s_tvalid && !in_acc) begin
				s_tvalid <= 1'b1;
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (sender_pause || pending_reqs.size() == 0) begin
				s_tvalid <= 1'b0;
			end else begin
				r = pending_reqs[0];
				if (in_acc && burst_left == 0 && $urandom_range(0, 2) == 0) begin
					s_tvalid <= 1'b0;
					gap_left <= $urandom_range(0, 6);
					burst_left <= $urandom_range(1, 8);
				end else begin
					s_tvalid <= 1'b1;
					s_tdata <= {r.addr, r.req_size};
					s_tuser <= r.func;
					if (in_acc && burst_left > 0) burst_left <= burst_left - 1;
				end
			end
		end
	end

	// receiver stall pattern and long hold-off
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
		end else if (hold_req && hold_left == 0) begin
			hold_left <= 3000;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= (hold_left == 1);
		end else begin
			m_tready <= ((cycles / 64) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
		end
	end

	// monitor: predict on input transaction, check on output transaction
	always @(posedge clk or negedge arst_n) begin
		grant_t want;
		if (!arst_n) begin
			cycles <= 0;
			in_acc <= 1'b0;
		end else begin
			cycles <= cycles + 1;
			in_acc <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				want = predict_heap(mk_req(s_tuser, s_tdata[15:0], s_tdata[31:16]));
				expected_grants.push_back(want);
				if (want.status != ST_OK) n_rejects++;
				else if (s_tuser == FUNC_ALLOC) begin
					n_alloc_ok++;
					live_payloads.push_back(want.payload);
				end else n_free_ok++;
			end
			if (m_tvalid && m_tready) begin
				if (expected_grants.size() == 0) begin
					$error("result transaction with nothing expected: %h", m_tdata);
					errors++;
				end else begin
					want = expected_grants.pop_front();
					if (m_tdata[2:0] !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, m_tdata[2:0]);
						errors++;
					end
					if (m_tdata[14:3] !== want.payload) begin
						$error("payload_address: expected %0d, actual %0d",
							want.payload, m_tdata[14:3]);
						errors++;
					end
					if (m_tdata[15] !== 1'b0) begin
						$error("pad bit: expected 0, actual %b", m_tdata[15]);
						errors++;
					end
				end
			end
			if (cycles > LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("** first_fit_heap_allocator: FAILED **");
				$finish;
			end
		end
	end

	task automatic wait_results();
		@(posedge clk);
		while (expected_grants.size() != 0 || s_tvalid) @(posedge clk);
	endtask

	task automatic drain_all();
		wait (pending_reqs.size() == 0);
		wait_results();
	endtask

	initial begin
		int k, idx, ad;
		errors = 0;
		n_alloc_ok = 0;
		n_free_ok = 0;
		n_rejects = 0;
		hold_req = 0;
		sender_pause = 0;
		for (int i = 0; i < ARENA; i++) heap_hdr[i] = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed
		pending_reqs.push_back(mk_req(FUNC_FREE, 0, 2));
		pending_reqs.push_back(mk_req(FUNC_ALLOC, 0, 16'hffff));
		pending_reqs.push_back(mk_req(FUNC_ALLOC, ARENA - 1, 0));
		pending_reqs.push_back(mk_req(FUNC_ALLOC, 16'hffff, 0));
		pending_reqs.push_back(mk_req(FUNC_ALLOC, ARENA - 2, 0));
		pending_reqs.push_back(mk_req(FUNC_ALLOC, 1, 0));
		pending_reqs.push_back(mk_req(FUNC_FREE, 0, 2));
		pending_reqs.push_back(mk_req(FUNC_FREE, 0, 2));
		pending_reqs.push_back(mk_req(FUNC_FREE, 0, 0));
		pending_reqs.push_back(mk_req(FUNC_FREE, 0, 1));
		pending_reqs.push_back(mk_req(FUNC_FREE, 0, ARENA));
		pending_reqs.push_back(mk_req(FUNC_FREE, 0, 16'hffff));
		pending_reqs.push_back(mk_req(FUNC_ALLOC, 1, 0));
		pending_reqs.push_back(mk_req(FUNC_ALLOC, 10, 0));
		pending_reqs.push_back(mk_req(FUNC_ALLOC, 10, 0));
		pending_reqs.push_back(mk_req(FUNC_ALLOC, 10, 0));
		pending_reqs.push_back(mk_req(FUNC_FREE, 0, 7));
		pending_reqs.push_back(mk_req(FUNC_FREE, 0, 18));
		pending_reqs.push_back(mk_req(FUNC_FREE, 0, 6));
		pending_reqs.push_back(mk_req(FUNC_ALLOC, 20, 0));
		pending_reqs.push_back(mk_req(FUNC_ALLOC, ARENA - 60, 0));
		pending_reqs.push_back(mk_req(FUNC_ALLOC, 4000, 0));
		pending_reqs.push_back(mk_req(FUNC_ALLOC, 2, 0));
		drain_all();

		// hold off the receiver while requests keep coming
		hold_req = 1;
		for (k = 0; k < 20; k++) pending_reqs.push_back(mk_req(FUNC_ALLOC, $urandom_range(1, 40), 0));
		wait (hold_left > 0);
		hold_req = 0;
		drain_all();

		// random: mostly frees, of live blocks or random addresses, and small allocates
		for (k = 0; k < 480; k++) begin
			if (pending_reqs.size() > 30) begin
				wait (pending_reqs.size() < 10);
			end
			if (k % 120 == 60) begin
				sender_pause = 1;
				wait_results();
				sender_pause = 0;
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3: pending_reqs.push_back(mk_req(FUNC_ALLOC, pick_size(),
					$urandom_range(0, 65535)));
				4, 5, 6: begin
					if (live_payloads.size() > 0) begin
						idx = $urandom_range(0, live_payloads.size() - 1);
						ad = live_payloads[idx];
						live_payloads.delete(idx);
					end else ad = $urandom_range(2, 200);
					pending_reqs.push_back(mk_req(FUNC_FREE, $urandom_range(0, 65535), ad));
				end
				7: pending_reqs.push_back(mk_req(FUNC_FREE, $urandom_range(0, 65535),
					$urandom_range(0, 65535)));
				default: pending_reqs.push_back(mk_req(FUNC_FREE, $urandom_range(0, 65535),
					$urandom_range(0, ARENA - 1)));
			endcase
		end
		drain_all();
		repeat (2000) @(posedge clk);

		$display("covered %0d good allocates, %0d good frees, %0d rejected requests",
			n_alloc_ok, n_free_ok, n_rejects);
		$display("with bursty input, receiver stalls and one long output hold-off");
		if (errors == 0 && expected_grants.size() == 0) begin
			$display("** first_fit_heap_allocator: PASSED **");
		end else begin
			$display("** first_fit_heap_allocator: FAILED **");
		end
		$finish;
	end
endmodule
